>>> sv/gmrc_pkg.sv
package gmrc_pkg;

	localparam int MAX_ROWS = 64;
	localparam int COLS     = 64;
	localparam int WORD_W   = 64;
	localparam int ROW_W    = 6;
	localparam int CNT_W    = 7;
	localparam int LANES    = 4;
	localparam int LANE_W   = 2;

	typedef enum logic [3:0] {
		OP_SET        = 4'd0,
		OP_GET        = 4'd1,
		OP_XOR_ROWS   = 4'd2,
		OP_XOR_COLS   = 4'd3,
		OP_SWAP_ROWS  = 4'd4,
		OP_SWAP_COLS  = 4'd5,
		OP_DEL_COL    = 4'd6,
		OP_DEL_FIRST  = 4'd7,
		OP_APPEND     = 4'd8,
		OP_XOR_VEC    = 4'd9,
		OP_KEEP_ONE   = 4'd10,
		OP_READ_ROW   = 4'd11,
		OP_READ_COL   = 4'd12,
		OP_ZERO_TEST  = 4'd13,
		OP_CLEAR      = 4'd14
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_PRECOND = 2'd2
	} status_t;

	// operation context shared by every lane during a sweep
	typedef struct packed {
		op_t                op;
		logic [ROW_W-1:0]   a;
		logic [ROW_W-1:0]   b;
		logic               bitv;
		logic               keep;
		logic [CNT_W-1:0]   ct;
		logic [CNT_W-1:0]   kcnt;
		logic [WORD_W-1:0]  vec;
		logic [WORD_W-1:0]  rowa;
		logic [WORD_W-1:0]  rowb;
	} lane_ctrl_t;

endpackage

>>> sv/gmrc_lane.sv
module gmrc_lane import gmrc_pkg::*; #(
	parameter int DEPTH   = 16,
	parameter int AW      = 4,
	parameter int LANE_ID = 0
) (
	input  logic                 clk,
	input  logic [AW-1:0]        rd_addr,
	input  logic [AW-1:0]        wr_addr,
	input  logic                 wr_en,
	input  logic                 live,
	input  lane_ctrl_t           ctrl,
	input  logic [ROW_W-1:0]     src_map [WORD_W],
	output logic [WORD_W-1:0]    cur,
	output logic [WORD_W-1:0]    nw
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [ROW_W-1:0]  row;
	logic [WORD_W-1:0] lowm;

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= nw;
		end
	end

	// rows never written since the last clear read as zero
	assign cur  = live ? rdata_q : '0;
	assign row  = ROW_W'(wr_addr) * ROW_W'(LANES) + ROW_W'(LANE_ID);
	assign lowm = (WORD_W'(1) << ctrl.a) - WORD_W'(1);

	always_comb begin
		nw = cur;
		unique case (ctrl.op)
			OP_SET: begin
				if (row == ctrl.a) nw[ctrl.b] = ctrl.bitv;
			end
			OP_XOR_ROWS: begin
				if (row == ctrl.b) nw = cur ^ ctrl.rowa;
			end
			OP_XOR_COLS: begin
				if (cur[ctrl.a]) nw[ctrl.b] = ~cur[ctrl.b];
			end
			OP_SWAP_ROWS: begin
				if (row == ctrl.a) nw = ctrl.rowb;
				else if (row == ctrl.b) nw = ctrl.rowa;
			end
			OP_SWAP_COLS: begin
				nw[ctrl.a] = cur[ctrl.b];
				nw[ctrl.b] = cur[ctrl.a];
			end
			OP_DEL_COL: begin
				nw = (cur & lowm) | ((cur >> (CNT_W'(ctrl.a) + CNT_W'(1))) << ctrl.a);
			end
			OP_DEL_FIRST: begin
				for (int k = 0; k < WORD_W; k++) begin
					nw[k] = (CNT_W'(k) < ctrl.kcnt) & cur[src_map[k]];
				end
			end
			OP_APPEND: begin
				nw[ctrl.ct[ROW_W-1:0]] = ctrl.vec[row];
			end
			OP_XOR_VEC: begin
				nw[ctrl.b] = cur[ctrl.b] ^ ctrl.vec[row];
			end
			OP_KEEP_ONE: begin
				if (row == ctrl.a) begin
					nw = ctrl.keep ? (WORD_W'(1) << ctrl.b) : (cur & (~cur + WORD_W'(1)));
				end
			end
			default: nw = cur;
		endcase
	end

endmodule

>>> sv/gmrc_merge.sv
module gmrc_merge import gmrc_pkg::*; #(
	parameter int AW = 4
) (
	input  logic                 clk,
	input  logic                 clr,
	input  logic                 valid,
	input  logic [AW-1:0]        addr,
	input  logic [ROW_W-1:0]     col_sel,
	input  logic [WORD_W-1:0]    cur [LANES],
	output logic [WORD_W-1:0]    col_or,
	output logic [WORD_W-1:0]    col_word
);

	logic [WORD_W-1:0] or_q;
	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (clr) begin
			or_q   <= '0;
			word_q <= '0;
		end else if (valid) begin
			for (int l = 0; l < LANES; l++) begin
				word_q[ROW_W'(addr) * ROW_W'(LANES) + ROW_W'(l)] <= cur[l][col_sel];
			end
			or_q <= or_q | cur[0] | cur[1] | cur[2] | cur[3];
		end
	end

	assign col_or   = or_q;
	assign col_word = word_q;

endmodule

>>> sv/gf2_matrix_row_column_engine.sv
// Errors, zero test and clear go straight to the finish state; get and row read only
// fetch rows; row/column updates and column read sweep the matrix (four lanes, one row
// each per cycle); mode 7 makes two sweeps with a compaction map build between them.
// One item at a time: start is taken again in the cycle that done pulses.
// arst_n clears the matrix (per-row live flags), column count 0, row count ROWS.
// done marks each result for one cycle; the receiver cannot stall.
module gf2_matrix_row_column_engine import gmrc_pkg::*; #(
	parameter int ROWS = MAX_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	input  logic                 cfg_write,
	input  logic [CNT_W-1:0]     cfg_data,
	input  logic [3:0]           mode,
	input  logic [6:0]           index_a,
	input  logic [5:0]           index_b,
	input  logic                 bit_value,
	input  logic                 keep_given,
	input  logic [WORD_W-1:0]    vector_bits,
	output logic                 bit_out,
	output logic [WORD_W-1:0]    word_out,
	output logic                 all_zero,
	output logic [CNT_W-1:0]     columns_now,
	output logic [1:0]           status
);

	localparam int DEPTH = (ROWS + LANES - 1) / LANES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_FA, S_FB, S_FC, S_SWEEP, S_DRAIN, S_CMAP, S_FINISH
	} state_t;

	state_t             state_q;
	op_t                op_q;
	status_t            st_q;
	status_t            st_new;
	logic [6:0]         a_q;
	logic [5:0]         b_q;
	logic               bitv_q, keep_q, pass_q;
	logic [WORD_W-1:0]  vec_q, rowa_q, rowb_q;
	logic [CNT_W-1:0]   rc_q, ct_q, k_q, cfg_v;
	logic [ROW_W-1:0]   c_q;
	logic [AW-1:0]      cnt_q, rd_addr, addr_s1;
	logic               sweep_s1;
	logic [MAX_ROWS-1:0] nz_q;
	logic [ROW_W-1:0]   src_q [WORD_W];
	logic [WORD_W-1:0]  cur [LANES];
	logic [WORD_W-1:0]  nw [LANES];
	logic [LANES-1:0]   live;
	logic               wr_en;
	lane_ctrl_t         ctrl;
	logic [WORD_W-1:0]  col_or, col_word;
	logic               ra, rb, ca, cb;

	assign busy = (state_q != S_IDLE);

	assign ra = index_a < rc_q;
	assign rb = {1'b0, index_b} < rc_q;
	assign ca = index_a < ct_q;
	assign cb = {1'b0, index_b} < ct_q;

	always_comb begin
		st_new = ST_OK;
		unique case (op_t'(mode))
			OP_SET, OP_GET:           if (!ra || !cb) st_new = ST_RANGE;
			OP_XOR_ROWS, OP_SWAP_ROWS: if (!ra || !rb) st_new = ST_RANGE;
			OP_XOR_COLS, OP_SWAP_COLS: if (!ca || !cb) st_new = ST_RANGE;
			OP_DEL_COL, OP_READ_COL:  if (!ca) st_new = ST_RANGE;
			OP_DEL_FIRST:             if (index_a == '0 || index_a > ct_q) st_new = ST_RANGE;
			OP_APPEND:                if (ct_q >= CNT_W'(COLS)) st_new = ST_PRECOND;
			OP_XOR_VEC:               if (!cb) st_new = ST_RANGE;
			OP_KEEP_ONE: begin
				if (!ra || (keep_given && !cb)) st_new = ST_RANGE;
				else if (!nz_q[index_a[ROW_W-1:0]]) st_new = ST_PRECOND;
			end
			OP_READ_ROW:              if (!ra) st_new = ST_RANGE;
			OP_ZERO_TEST:             st_new = ST_OK;
			OP_CLEAR:                 if (index_a > CNT_W'(COLS)) st_new = ST_RANGE;
			default:                  st_new = ST_RANGE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_FA:    rd_addr = AW'(a_q[ROW_W-1:0] / LANES);
			S_FB:    rd_addr = AW'(b_q / LANES);
			default: rd_addr = cnt_q;
		endcase
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			live[l] = nz_q[ROW_W'(addr_s1) * ROW_W'(LANES) + ROW_W'(l)];
		end
	end

	assign wr_en = sweep_s1 && !(op_q == OP_READ_COL) && !(op_q == OP_DEL_FIRST && !pass_q);

	assign cfg_v = (cfg_data == '0) ? CNT_W'(1) :
	               (cfg_data > CNT_W'(ROWS)) ? CNT_W'(ROWS) : cfg_data;

	always_comb begin
		ctrl.op   = op_q;
		ctrl.a    = a_q[ROW_W-1:0];
		ctrl.b    = b_q;
		ctrl.bitv = bitv_q;
		ctrl.keep = keep_q;
		ctrl.ct   = ct_q;
		ctrl.kcnt = k_q;
		ctrl.vec  = vec_q;
		ctrl.rowa = rowa_q;
		ctrl.rowb = rowb_q;
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		gmrc_lane #(.DEPTH(DEPTH), .AW(AW), .LANE_ID(l)) u_lane (
			.clk     (clk),
			.rd_addr (rd_addr),
			.wr_addr (addr_s1),
			.wr_en   (wr_en),
			.live    (live[l]),
			.ctrl    (ctrl),
			.src_map (src_q),
			.cur     (cur[l]),
			.nw      (nw[l])
		);
	end

	gmrc_merge #(.AW(AW)) u_merge (
		.clk      (clk),
		.clr      (state_q == S_FC),
		.valid    (sweep_s1),
		.addr     (addr_s1),
		.col_sel  (a_q[ROW_W-1:0]),
		.cur      (cur),
		.col_or   (col_or),
		.col_word (col_word)
	);

	// compaction map entries need no reset
	always_ff @(posedge clk) begin
		if (state_q == S_CMAP && col_or[c_q] && {1'b0, c_q} >= a_q) begin
			src_q[k_q[ROW_W-1:0]] <= c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ZERO_TEST;
			st_q        <= ST_OK;
			a_q         <= '0;
			b_q         <= '0;
			bitv_q      <= 1'b0;
			keep_q      <= 1'b0;
			pass_q      <= 1'b0;
			vec_q       <= '0;
			rowa_q      <= '0;
			rowb_q      <= '0;
			rc_q        <= CNT_W'(ROWS);
			ct_q        <= '0;
			k_q         <= '0;
			c_q         <= '0;
			cnt_q       <= '0;
			addr_s1     <= '0;
			sweep_s1    <= 1'b0;
			nz_q        <= '0;
			done        <= 1'b0;
			bit_out     <= 1'b0;
			word_out    <= '0;
			all_zero    <= 1'b1;
			columns_now <= '0;
			status      <= ST_OK;
		end else begin
			done     <= 1'b0;
			addr_s1  <= rd_addr;
			sweep_s1 <= (state_q == S_SWEEP);
			if (wr_en) begin
				for (int l = 0; l < LANES; l++) begin
					if (ROW_W'(addr_s1) * ROW_W'(LANES) + ROW_W'(l) < ROW_W'(ROWS - 1) + ROW_W'(1)
					    || ROWS == MAX_ROWS) begin
						nz_q[ROW_W'(addr_s1) * ROW_W'(LANES) + ROW_W'(l)] <= |nw[l];
					end
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q   <= op_t'(mode);
						st_q   <= st_new;
						a_q    <= index_a;
						b_q    <= index_b;
						bitv_q <= bit_value;
						keep_q <= keep_given;
						pass_q <= 1'b0;
						vec_q  <= vector_bits & ~({WORD_W{1'b1}} << rc_q);
						if (st_new != ST_OK || op_t'(mode) == OP_ZERO_TEST) begin
							state_q <= S_FINISH;
						end else if (op_t'(mode) == OP_CLEAR) begin
							nz_q    <= '0;
							ct_q    <= index_a;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_FA;
						end
					end else if (cfg_write) begin
						rc_q <= cfg_v;
						for (int r = 0; r < MAX_ROWS; r++) begin
							if (CNT_W'(r) >= cfg_v) nz_q[r] <= 1'b0;
						end
					end
				end
				S_FA: state_q <= S_FB;
				S_FB: begin
					rowa_q  <= cur[a_q[LANE_W-1:0]];
					state_q <= S_FC;
				end
				S_FC: begin
					rowb_q <= cur[b_q[LANE_W-1:0]];
					cnt_q  <= '0;
					if (op_q == OP_GET || op_q == OP_READ_ROW) state_q <= S_FINISH;
					else state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(DEPTH - 1)) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (op_q == OP_DEL_FIRST && !pass_q) begin
						c_q     <= '0;
						k_q     <= '0;
						state_q <= S_CMAP;
					end else begin
						unique case (op_q)
							OP_DEL_COL:   ct_q <= ct_q - CNT_W'(1);
							OP_APPEND:    ct_q <= ct_q + CNT_W'(1);
							OP_DEL_FIRST: ct_q <= k_q;
							default:      ct_q <= ct_q;
						endcase
						state_q <= S_FINISH;
					end
				end
				S_CMAP: begin
					// keep a column at or past the cut that holds any set bit
					if (col_or[c_q] && {1'b0, c_q} >= a_q) k_q <= k_q + CNT_W'(1);
					c_q <= c_q + ROW_W'(1);
					if (c_q == ROW_W'(WORD_W - 1)) begin
						pass_q  <= 1'b1;
						cnt_q   <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_FINISH: begin
					done        <= 1'b1;
					bit_out     <= (st_q == ST_OK && op_q == OP_GET) ? rowa_q[b_q] : 1'b0;
					word_out    <= (st_q != ST_OK) ? '0 :
					               (op_q == OP_READ_ROW) ? rowa_q :
					               (op_q == OP_READ_COL) ? col_word : '0;
					all_zero    <= ~|nz_q;
					columns_now <= ct_q;
					status      <= st_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
